>>> rtl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// kwl_pkg: shared definitions of the keyword token lexer
// Token and error codes, scanner state codes, character constants, the
// keyword table and the character class helpers.
// ----------------------------------------------------------------------------
package kwl_pkg;

	// Default widths of the counters and of the token fields
	localparam int DEF_LINE_BITS     = 16;
	localparam int DEF_POSITION_BITS = 20;
	localparam int DEF_LENGTH_BITS   = 8;

	// Fixed field widths
	localparam int TYPE_W  = 6;
	localparam int CHAR_W  = 8;
	localparam int ERR_W   = 3;
	localparam int STATE_W = 3;

	// Identifier buffer and keyword table
	localparam int WORD_MAX = 9;
	localparam int WORD_W   = WORD_MAX * CHAR_W;
	localparam int KW_COUNT = 21;

	// Result queue depth (power of two)
	localparam int FIFO_DEPTH = 4;

	// Scanner states
	localparam logic [STATE_W-1:0] S_START   = 3'd0;
	localparam logic [STATE_W-1:0] S_ID      = 3'd1;
	localparam logic [STATE_W-1:0] S_NUM     = 3'd2;
	localparam logic [STATE_W-1:0] S_ASSIGN  = 3'd3;
	localparam logic [STATE_W-1:0] S_COMMENT = 3'd4;
	localparam logic [STATE_W-1:0] S_RANGE   = 3'd5;
	localparam logic [STATE_W-1:0] S_CHAR    = 3'd6;
	localparam logic [STATE_W-1:0] S_CHARV   = 3'd7;

	// Token types
	localparam logic [TYPE_W-1:0] T_EOF      = 6'd0;
	localparam logic [TYPE_W-1:0] T_ERR      = 6'd1;
	localparam logic [TYPE_W-1:0] T_KW_FIRST = 6'd2;
	localparam logic [TYPE_W-1:0] T_ID       = 6'd23;
	localparam logic [TYPE_W-1:0] T_NUM      = 6'd24;
	localparam logic [TYPE_W-1:0] T_CHARC    = 6'd25;
	localparam logic [TYPE_W-1:0] T_PLUS     = 6'd26;
	localparam logic [TYPE_W-1:0] T_MINUS    = 6'd27;
	localparam logic [TYPE_W-1:0] T_TIMES    = 6'd28;
	localparam logic [TYPE_W-1:0] T_OVER     = 6'd29;
	localparam logic [TYPE_W-1:0] T_EQ       = 6'd30;
	localparam logic [TYPE_W-1:0] T_LT       = 6'd31;
	localparam logic [TYPE_W-1:0] T_LPAREN   = 6'd32;
	localparam logic [TYPE_W-1:0] T_RPAREN   = 6'd33;
	localparam logic [TYPE_W-1:0] T_LBRACK   = 6'd34;
	localparam logic [TYPE_W-1:0] T_RBRACK   = 6'd35;
	localparam logic [TYPE_W-1:0] T_SEMI     = 6'd36;
	localparam logic [TYPE_W-1:0] T_COMMA    = 6'd37;
	localparam logic [TYPE_W-1:0] T_ASSIGN   = 6'd38;
	localparam logic [TYPE_W-1:0] T_COLON    = 6'd39;
	localparam logic [TYPE_W-1:0] T_DOT      = 6'd40;
	localparam logic [TYPE_W-1:0] T_RANGE    = 6'd41;

	// Error kinds
	localparam logic [ERR_W-1:0] E_NONE         = 3'd0;
	localparam logic [ERR_W-1:0] E_OPEN_COMMENT = 3'd1;
	localparam logic [ERR_W-1:0] E_OPEN_CHAR    = 3'd2;
	localparam logic [ERR_W-1:0] E_NOT_SINGLE   = 3'd3;
	localparam logic [ERR_W-1:0] E_INVALID_CHAR = 3'd4;
	localparam logic [ERR_W-1:0] E_ILLEGAL      = 3'd5;

	// Characters with a role of their own
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;

	// Keywords, right aligned with zero fill: the buffer shifts bytes in
	// from the low end, so a word of n bytes lines up with its literal.
	localparam logic [WORD_W-1:0] KW_TEXT [KW_COUNT] = '{
		"program", "type", "var", "procedure", "begin", "end", "array",
		"of", "record", "if", "then", "else", "fi", "while", "do", "endwh",
		"read", "write", "return", "integer", "char"
	};

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return is_alpha(c) || is_digit(c);
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// One-character operators; anything else is an illegal byte
	function automatic logic [TYPE_W-1:0] single_op(input logic [CHAR_W-1:0] c);
		logic [TYPE_W-1:0] t;
		unique case (c)
			"+":     t = T_PLUS;
			"-":     t = T_MINUS;
			"*":     t = T_TIMES;
			"/":     t = T_OVER;
			"=":     t = T_EQ;
			"<":     t = T_LT;
			"(":     t = T_LPAREN;
			")":     t = T_RPAREN;
			"[":     t = T_LBRACK;
			"]":     t = T_RBRACK;
			";":     t = T_SEMI;
			",":     t = T_COMMA;
			default: t = T_ERR;
		endcase
		return t;
	endfunction

endpackage

>>> rtl/kwl_byte_if.sv
// ----------------------------------------------------------------------------
// kwl_byte_if: source byte channel
// Valid/ready channel carrying one source byte per item.
// ----------------------------------------------------------------------------
interface kwl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

>>> rtl/kwl_token_if.sv
// ----------------------------------------------------------------------------
// kwl_token_if: token channel
// Valid/ready channel carrying one token item with its position fields.
// ----------------------------------------------------------------------------
interface kwl_token_if
	import kwl_pkg::*;
#(
	parameter int LINE_BITS     = DEF_LINE_BITS,
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int LENGTH_BITS   = DEF_LENGTH_BITS
);
	logic                     valid;
	logic                     ready;
	logic [TYPE_W-1:0]        token_type;
	logic [LINE_BITS-1:0]     token_line;
	logic [POSITION_BITS-1:0] token_start;
	logic [LENGTH_BITS-1:0]   token_length;
	logic [CHAR_W-1:0]        char_value;
	logic [ERR_W-1:0]         error_kind;
	logic                     last;

	modport source (
		output valid, output token_type, output token_line, output token_start,
		output token_length, output char_value, output error_kind, output last,
		input ready
	);
	modport sink (
		input valid, input token_type, input token_line, input token_start,
		input token_length, input char_value, input error_kind, input last,
		output ready
	);
endinterface

>>> rtl/kwl_keyword.sv
// ----------------------------------------------------------------------------
// kwl_keyword: keyword lookup
// Compares the identifier buffer against the fixed keyword table and gives
// the keyword's token type, or the identifier type when nothing matches.
// ----------------------------------------------------------------------------
module kwl_keyword
	import kwl_pkg::*;
#(
	parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
	input  logic [WORD_W-1:0]      word,
	input  logic                   overflow,
	input  logic [LENGTH_BITS-1:0] length,
	output logic [TYPE_W-1:0]      kind
);

	// Match every table entry in parallel; entries are distinct
	always_comb begin
		kind = T_ID;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (!overflow && length <= LENGTH_BITS'(WORD_MAX) && word == KW_TEXT[k]) begin
				kind = T_KW_FIRST + TYPE_W'(k);
			end
		end
	end

endmodule

>>> rtl/kwl_scan.sv
// ----------------------------------------------------------------------------
// kwl_scan: input register and lexer state machine
// Holds one byte in the input register, runs the token state machine on it
// and produces up to two token items per byte for the result queue.
// ----------------------------------------------------------------------------
module kwl_scan
	import kwl_pkg::*;
#(
	parameter int LINE_BITS     = DEF_LINE_BITS,
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int LENGTH_BITS   = DEF_LENGTH_BITS,
	parameter int TOK_W         = TYPE_W + LINE_BITS + POSITION_BITS + LENGTH_BITS
	                              + CHAR_W + ERR_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	kwl_byte_if.sink         src,
	input  logic             room,
	output logic [1:0]       push_count,
	output logic [TOK_W-1:0] push_tok0,
	output logic [TOK_W-1:0] push_tok1
);

	logic                     v_s1;
	logic [CHAR_W-1:0]        ch_s1;
	logic                     step_en;

	logic [STATE_W-1:0]       state_q;
	logic [WORD_W-1:0]        word_q;
	logic                     ovf_q;
	logic [LENGTH_BITS-1:0]   len_q;
	logic [LINE_BITS-1:0]     line_q;
	logic [LINE_BITS-1:0]     sline_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] spos_q;
	logic [CHAR_W-1:0]        held_q;

	logic [STATE_W-1:0]       st_n;
	logic [WORD_W-1:0]        word_n;
	logic                     ovf_n;
	logic [LENGTH_BITS-1:0]   len_n;
	logic [LINE_BITS-1:0]     sline_n;
	logic [POSITION_BITS-1:0] spos_n;
	logic [CHAR_W-1:0]        held_n;

	logic                     redo;
	logic                     a_v;
	logic [TYPE_W-1:0]        a_type;
	logic [LENGTH_BITS-1:0]   a_len;
	logic [CHAR_W-1:0]        a_cv;
	logic [ERR_W-1:0]         a_err;
	logic                     b_v;
	logic [TYPE_W-1:0]        b_type;
	logic [LENGTH_BITS-1:0]   b_len;
	logic [ERR_W-1:0]         b_err;
	logic [TYPE_W-1:0]        kw_kind;
	logic [TOK_W-1:0]         tok_a;
	logic [TOK_W-1:0]         tok_b;

	function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] x);
		return (x == '1) ? x : x + 1'b1;
	endfunction

	// Input register: take a byte when none is held or the held one moves on
	assign src.ready = !v_s1 || room;
	assign step_en   = v_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src.valid && src.ready) begin
			v_s1 <= 1'b1;
		end else if (step_en) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			ch_s1 <= src.ch;
		end
	end

	kwl_keyword #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_keyword (
		.word     (word_q),
		.overflow (ovf_q),
		.length   (len_q),
		.kind     (kw_kind)
	);

	// Token state machine: finish the open token, then rescan from start
	always_comb begin
		st_n    = state_q;
		word_n  = word_q;
		ovf_n   = ovf_q;
		len_n   = len_q;
		sline_n = sline_q;
		spos_n  = spos_q;
		held_n  = held_q;
		redo    = (state_q == S_START);
		a_v     = 1'b0;
		a_type  = T_ID;
		a_cv    = '0;
		a_err   = E_NONE;

		unique case (state_q)
			S_ID: begin
				if (is_alnum(ch_s1)) begin
					if (len_n < LENGTH_BITS'(WORD_MAX)) begin
						word_n = {word_n[WORD_W-CHAR_W-1:0], ch_s1};
					end else begin
						ovf_n = 1'b1;
					end
					len_n = sat_inc(len_n);
				end else begin
					a_v    = 1'b1;
					a_type = kw_kind;
					redo   = 1'b1;
				end
			end
			S_NUM: begin
				if (is_digit(ch_s1)) begin
					len_n = sat_inc(len_n);
				end else begin
					a_v    = 1'b1;
					a_type = T_NUM;
					redo   = 1'b1;
				end
			end
			S_ASSIGN: begin
				a_v = 1'b1;
				if (ch_s1 == CH_EQ) begin
					len_n  = sat_inc(len_n);
					a_type = T_ASSIGN;
				end else begin
					a_type = T_COLON;
					redo   = 1'b1;
				end
			end
			S_RANGE: begin
				a_v = 1'b1;
				if (ch_s1 == CH_DOT) begin
					len_n  = sat_inc(len_n);
					a_type = T_RANGE;
				end else begin
					a_type = T_DOT;
					redo   = 1'b1;
				end
			end
			S_COMMENT: begin
				if (ch_s1 == CH_NUL) begin
					a_v    = 1'b1;
					a_type = T_ERR;
					a_err  = E_OPEN_COMMENT;
					redo   = 1'b1;
				end else if (ch_s1 == CH_RBRACE) begin
					st_n = S_START;
				end else begin
					len_n = sat_inc(len_n);
				end
			end
			S_CHAR: begin
				if (ch_s1 == CH_NUL) begin
					a_v    = 1'b1;
					a_type = T_ERR;
					a_err  = E_OPEN_CHAR;
					redo   = 1'b1;
				end else begin
					len_n = sat_inc(len_n);
					if (ch_s1 == CH_NL) begin
						a_v    = 1'b1;
						a_type = T_ERR;
						a_err  = E_OPEN_CHAR;
					end else if (is_alnum(ch_s1)) begin
						held_n = ch_s1;
						st_n   = S_CHARV;
					end else begin
						a_v    = 1'b1;
						a_type = T_ERR;
						a_err  = E_INVALID_CHAR;
					end
				end
			end
			S_CHARV: begin
				a_v = 1'b1;
				if (ch_s1 == CH_QUOTE) begin
					len_n  = sat_inc(len_n);
					a_type = T_CHARC;
					a_cv   = held_q;
				end else begin
					a_type = T_ERR;
					a_err  = E_NOT_SINGLE;
					redo   = 1'b1;
				end
			end
			default: begin
				// start state: all work is in the rescan below
			end
		endcase

		if (a_v) begin
			st_n = S_START;
		end
		a_len = len_n;

		// Rescan from the start state
		b_v    = 1'b0;
		b_type = T_EOF;
		b_len  = '0;
		b_err  = E_NONE;
		if (redo && !is_space(ch_s1)) begin
			sline_n = line_q;
			spos_n  = pos_q;
			len_n   = '0;
			ovf_n   = 1'b0;
			word_n  = '0;
			held_n  = '0;
			st_n    = S_START;
			if (ch_s1 == CH_NUL) begin
				b_v = 1'b1;
			end else if (is_alpha(ch_s1)) begin
				word_n = {{(WORD_W-CHAR_W){1'b0}}, ch_s1};
				len_n  = LENGTH_BITS'(1);
				st_n   = S_ID;
			end else begin
				len_n = LENGTH_BITS'(1);
				priority if (is_digit(ch_s1)) begin
					st_n = S_NUM;
				end else if (ch_s1 == CH_COLON) begin
					st_n = S_ASSIGN;
				end else if (ch_s1 == CH_LBRACE) begin
					st_n = S_COMMENT;
				end else if (ch_s1 == CH_DOT) begin
					st_n = S_RANGE;
				end else if (ch_s1 == CH_QUOTE) begin
					st_n = S_CHAR;
				end else begin
					b_v    = 1'b1;
					b_type = single_op(ch_s1);
					b_len  = len_n;
					b_err  = (b_type == T_ERR) ? E_ILLEGAL : E_NONE;
				end
			end
		end
	end

	// Pack the items; the second token of a byte always comes from the rescan
	assign tok_a = {a_type, sline_q, spos_q, a_len, a_cv, a_err, !b_v};
	assign tok_b = {b_type, sline_n, spos_n, b_len, {CHAR_W{1'b0}}, b_err, 1'b1};

	assign push_tok0  = a_v ? tok_a : tok_b;
	assign push_tok1  = tok_b;
	assign push_count = step_en ? (2'(a_v) + 2'(b_v)) : 2'd0;

	// State registers: advance once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			word_q  <= '0;
			ovf_q   <= 1'b0;
			len_q   <= '0;
			line_q  <= LINE_BITS'(1);
			sline_q <= LINE_BITS'(1);
			pos_q   <= '0;
			spos_q  <= '0;
			held_q  <= '0;
		end else if (step_en) begin
			state_q <= st_n;
			word_q  <= word_n;
			ovf_q   <= ovf_n;
			len_q   <= len_n;
			sline_q <= sline_n;
			spos_q  <= spos_n;
			held_q  <= held_n;
			if (ch_s1 == CH_NL && line_q != '1) begin
				line_q <= line_q + 1'b1;
			end
			if (pos_q != '1) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/kwl_token_fifo.sv
// ----------------------------------------------------------------------------
// kwl_token_fifo: result queue
// Small queue that takes up to two token items per cycle and, if read, hands
// out one per cycle; it signals room while two free entries are guaranteed.
// ----------------------------------------------------------------------------
module kwl_token_fifo
	import kwl_pkg::*;
#(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_count,
	input  logic [WIDTH-1:0] push_tok0,
	input  logic [WIDTH-1:0] push_tok1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_tok
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [WIDTH-1:0] entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign room      = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_tok   = entry_q[head_q];
	assign pop       = out_valid && out_ready;

	// Write the new items at the tail, in order
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[tail_q] <= push_tok0;
		end
		if (push_count == 2'd2) begin
			entry_q[tail_q + 1'b1] <= push_tok1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + PTR_W'(push_count);
			head_q  <= head_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_count) - CNT_W'(pop);
		end
	end

endmodule

>>> rtl/keyword_token_lexer.sv
// ----------------------------------------------------------------------------
// keyword_token_lexer: byte-serial lexer with keyword lookup
// Top level: input register and state machine, followed by a result queue.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per cycle on src (byte 0 ends the input)
// and delivers tokens on tokens, each with its type, first line, start
// position, length, character value and error kind; last marks the final
// token caused by a byte. A byte goes through one input register, the state
// machine and keyword compare act on it combinationally, and its tokens
// enter a four-entry queue whose head drives the output. Input is taken
// every cycle as long as the queue has two free entries; a byte that ends
// one token and starts another gives two tokens, which the queue drains one
// per cycle while the token channel is ready.
// ----------------------------------------------------------------------------
module keyword_token_lexer
	import kwl_pkg::*;
#(
	parameter int LINE_BITS     = DEF_LINE_BITS,
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	kwl_byte_if.sink    src,
	kwl_token_if.source tokens
);

	localparam int TOK_W = TYPE_W + LINE_BITS + POSITION_BITS + LENGTH_BITS
	                       + CHAR_W + ERR_W + 1;

	logic             room;
	logic [1:0]       push_count;
	logic [TOK_W-1:0] push_tok0;
	logic [TOK_W-1:0] push_tok1;
	logic [TOK_W-1:0] head_tok;

	kwl_scan #(
		.LINE_BITS     (LINE_BITS),
		.POSITION_BITS (POSITION_BITS),
		.LENGTH_BITS   (LENGTH_BITS),
		.TOK_W         (TOK_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.room       (room),
		.push_count (push_count),
		.push_tok0  (push_tok0),
		.push_tok1  (push_tok1)
	);

	kwl_token_fifo #(
		.WIDTH (TOK_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push_tok0  (push_tok0),
		.push_tok1  (push_tok1),
		.room       (room),
		.out_valid  (tokens.valid),
		.out_ready  (tokens.ready),
		.out_tok    (head_tok)
	);

	// Unpack the queue head onto the token channel
	assign {tokens.token_type, tokens.token_line, tokens.token_start, tokens.token_length,
	        tokens.char_value, tokens.error_kind, tokens.last} = head_tok;

endmodule

>>> rtl/kwl_checker.sv
// ----------------------------------------------------------------------------
// kwl_checker: port-level checks of the lexer
// Watches the token channel and checks the consistency of token fields.
// ----------------------------------------------------------------------------
module kwl_checker
	import kwl_pkg::*;
#(
	parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   tok_valid,
	input logic                   tok_ready,
	input logic [TYPE_W-1:0]      tok_type,
	input logic [LENGTH_BITS-1:0] tok_length,
	input logic [CHAR_W-1:0]      tok_char,
	input logic [ERR_W-1:0]       tok_err,
	input logic                   tok_last
);

	// Hold a stalled item
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid)
		else $error("token item dropped while stalled");

	// End of file token is empty and closes its byte
	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_type == T_EOF |-> tok_length == '0 && tok_last)
		else $error("end of file token malformed");

	// Only a character constant carries a character value
	a_char_value: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_char != '0 |-> tok_type == T_CHARC)
		else $error("character value on a non-character token");

	// Error kind is set exactly on error tokens
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((tok_err != E_NONE) == (tok_type == T_ERR)))
		else $error("error kind inconsistent with token type");

endmodule

bind keyword_token_lexer kwl_checker #(
	.LENGTH_BITS (LENGTH_BITS)
) u_kwl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tokens.valid),
	.tok_ready  (tokens.ready),
	.tok_type   (tokens.token_type),
	.tok_length (tokens.token_length),
	.tok_char   (tokens.char_value),
	.tok_err    (tokens.error_kind),
	.tok_last   (tokens.last)
);
